>>> rtl/slta_pkg.sv
`default_nettype none
package slta_pkg;

  localparam int VARS = 1024;
  localparam int IW = 10;
  localparam int WW = 32;
  localparam int AW = 64;
  localparam int DEF_MAX_CROSS = 16;
  localparam int DEF_MAX_LIST = 8;

  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STS_DONE     = 2'd0,
    STS_BUFFERED = 2'd1,
    STS_ROW_FULL = 2'd2,
    STS_BUF_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    K_ACK   = 2'd0,
    K_EQ    = 2'd1,
    K_CLEAR = 2'd2,
    K_READ  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    BK_INIT,
    BK_IDLE,
    BK_RD_OUT,
    BK_CLR,
    BK_EQ_CSQ,
    BK_EQ_CADD,
    BK_P_NEXT,
    BK_P_LIN,
    BK_P_SQ,
    BK_Q_NEXT,
    BK_Q_FILL,
    BK_Q_CMP,
    BK_Q_APP
  } state_e;

  typedef struct packed {
    kind_e                 kind;
    status_e               sts;
    logic                  drop;
    logic [IW-1:0]         idx;
    logic [3:0]            slot;
    logic signed [WW-1:0]  cnst;
  } cmd_t;

  function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                   input logic signed [AW-1:0] b);
    logic signed [AW-1:0] s;
    s = a + b;
    if (a[AW-1] == b[AW-1] && s[AW-1] != a[AW-1]) begin
      return a[AW-1] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [AW-1:0] sat_dbl(input logic signed [AW-1:0] x);
    if (x[AW-1] != x[AW-2]) begin
      return x[AW-1] ? ACC_MIN : ACC_MAX;
    end
    return {x[AW-2:0], 1'b0};
  endfunction

endpackage
`default_nettype wire

>>> rtl/sparse_lsq_term_accumulator_unit.sv
// Sequencing in the back sequencer: a buffered element or unused request is answered
//   from the idle state; a read passes through a memory read and BK_RD_OUT; a clear sweeps
//   all 1024*MAX_CROSS row slots; an equation squares its constant, updates per-element
//   terms, then per pair adds into a matching column, appends one or flags the row full.
// Throughput: one request at a time in the back sequencer; a 2-entry command queue lets
//   the front keep taking transfers while a result waits to be popped.
// Reset: asynchronous, active low; afterwards a sweep over all 1024 rows zeroes the
//   per-row terms and fill counts, with full held high until it ends.
`default_nettype none
module sparse_lsq_term_accumulator_unit #(
  parameter int MAX_CROSS = slta_pkg::DEF_MAX_CROSS,
  parameter int MAX_LIST  = slta_pkg::DEF_MAX_LIST
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [1:0]                       req_type_i,
  input  wire logic [slta_pkg::IW-1:0]          var_index_i,
  input  wire logic signed [slta_pkg::WW-1:0]   weight_i,
  input  wire logic signed [slta_pkg::WW-1:0]   eq_constant_i,
  input  wire logic                             last_element_i,
  input  wire logic [3:0]                       slot_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [1:0]                            status_o,
  output logic signed [slta_pkg::AW-1:0]        linear_value_o,
  output logic signed [slta_pkg::AW-1:0]        square_value_o,
  output logic [4:0]                            cross_used_o,
  output logic [slta_pkg::IW-1:0]               cross_col_o,
  output logic signed [slta_pkg::AW-1:0]        cross_value_o,
  output logic signed [slta_pkg::AW-1:0]        const_value_o
);
  import slta_pkg::*;

  localparam int CW = $clog2(MAX_LIST + 1);
  localparam int DW = MAX_LIST * WW + MAX_LIST * IW + CW + $bits(cmd_t);

  logic                     acc;
  logic                     q_full, q_valid, q_pop, init_busy;
  cmd_t                     f_cmd, b_cmd;
  logic [CW-1:0]            f_cnt, b_cnt;
  logic [MAX_LIST*IW-1:0]   f_lidx, b_lidx;
  logic [MAX_LIST*WW-1:0]   f_lwt, b_lwt;
  logic [DW-1:0]            q_out;

  // Hold off transfers while the queue is full or the reset sweep runs.
  assign full = q_full || init_busy;
  assign acc  = push && !full;

  // Front: buffer elements, classify the request, build one command per transfer.
  slta_front #(.MAX_LIST(MAX_LIST)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (acc),
    .req_type_i     (req_type_i),
    .var_index_i    (var_index_i),
    .weight_i       (weight_i),
    .eq_constant_i  (eq_constant_i),
    .last_element_i (last_element_i),
    .slot_i         (slot_i),
    .cmd_o          (f_cmd),
    .cnt_o          (f_cnt),
    .lidx_o         (f_lidx),
    .lwt_o          (f_lwt)
  );

  slta_cmd_fifo #(.DW(DW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .data_i  ({f_lwt, f_lidx, f_cnt, f_cmd}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign {b_lwt, b_lidx, b_cnt, b_cmd} = q_out;

  // Back: sequence the memory updates and hold one result for the consumer.
  slta_back #(.MAX_CROSS(MAX_CROSS), .MAX_LIST(MAX_LIST)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (b_cmd),
    .cnt_i          (b_cnt),
    .lidx_i         (b_lidx),
    .lwt_i          (b_lwt),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .init_busy_o    (init_busy),
    .pop_i          (pop),
    .empty_o        (empty),
    .status_o       (status_o),
    .linear_value_o (linear_value_o),
    .square_value_o (square_value_o),
    .cross_used_o   (cross_used_o),
    .cross_col_o    (cross_col_o),
    .cross_value_o  (cross_value_o),
    .const_value_o  (const_value_o)
  );

endmodule
`default_nettype wire

>>> rtl/slta_front.sv
`default_nettype none
module slta_front #(
  parameter int MAX_LIST = slta_pkg::DEF_MAX_LIST
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    acc_i,
  input  wire logic [1:0]                              req_type_i,
  input  wire logic [slta_pkg::IW-1:0]                 var_index_i,
  input  wire logic signed [slta_pkg::WW-1:0]          weight_i,
  input  wire logic signed [slta_pkg::WW-1:0]          eq_constant_i,
  input  wire logic                                    last_element_i,
  input  wire logic [3:0]                              slot_i,
  output slta_pkg::cmd_t                               cmd_o,
  output logic [$clog2(MAX_LIST+1)-1:0]                cnt_o,
  output logic [MAX_LIST*slta_pkg::IW-1:0]             lidx_o,
  output logic [MAX_LIST*slta_pkg::WW-1:0]             lwt_o
);
  import slta_pkg::*;

  localparam int CW = $clog2(MAX_LIST + 1);

  logic [IW-1:0]        pend_idx_q [MAX_LIST];
  logic signed [WW-1:0] pend_wt_q  [MAX_LIST];
  logic [CW-1:0]        pcount_q, pcount_d;
  logic                 drop;
  logic                 is_add;

  assign drop   = 32'(pcount_q) >= MAX_LIST;
  assign is_add = req_e'(req_type_i) == REQ_ADD;

  always_comb begin
    cmd_o.kind = K_ACK;
    cmd_o.sts  = STS_DONE;
    cmd_o.drop = drop;
    cmd_o.idx  = var_index_i;
    cmd_o.slot = slot_i;
    cmd_o.cnst = eq_constant_i;
    case (req_e'(req_type_i))
      REQ_ADD: begin
        if (last_element_i) begin
          cmd_o.kind = K_EQ;
        end else begin
          cmd_o.sts = drop ? STS_BUF_FULL : STS_BUFFERED;
        end
      end
      REQ_CLEAR: cmd_o.kind = K_CLEAR;
      REQ_READ:  cmd_o.kind = K_READ;
      default:   cmd_o.kind = K_ACK;
    endcase
  end

  // Hand over the buffered list with the closing element merged in.
  always_comb begin
    for (int i = 0; i < MAX_LIST; i++) begin
      if (pcount_q == CW'(i) && !drop) begin
        lidx_o[i*IW +: IW] = var_index_i;
        lwt_o[i*WW +: WW]  = weight_i;
      end else begin
        lidx_o[i*IW +: IW] = pend_idx_q[i];
        lwt_o[i*WW +: WW]  = pend_wt_q[i];
      end
    end
    cnt_o = pcount_q + CW'(!drop);
  end

  always_comb begin
    pcount_d = pcount_q;
    if (acc_i && is_add) begin
      pcount_d = last_element_i ? '0 : pcount_q + CW'(!drop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= '0;
    end else begin
      pcount_q <= pcount_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_LIST; i++) begin
      if (acc_i && is_add && !drop && pcount_q == CW'(i)) begin
        pend_idx_q[i] <= var_index_i;
        pend_wt_q[i]  <= weight_i;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/slta_cmd_fifo.sv
`default_nettype none
module slta_cmd_fifo #(
  parameter int DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output logic [DW-1:0]      data_o
);

  logic [DW-1:0] mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/slta_back.sv
`default_nettype none
module slta_back #(
  parameter int MAX_CROSS = slta_pkg::DEF_MAX_CROSS,
  parameter int MAX_LIST  = slta_pkg::DEF_MAX_LIST
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  slta_pkg::cmd_t                           cmd_i,
  input  wire logic [$clog2(MAX_LIST+1)-1:0]       cnt_i,
  input  wire logic [MAX_LIST*slta_pkg::IW-1:0]    lidx_i,
  input  wire logic [MAX_LIST*slta_pkg::WW-1:0]    lwt_i,
  input  wire logic                                q_valid_i,
  output logic                                     q_pop_o,
  output logic                                     init_busy_o,
  input  wire logic                                pop_i,
  output logic                                     empty_o,
  output logic [1:0]                               status_o,
  output logic signed [slta_pkg::AW-1:0]           linear_value_o,
  output logic signed [slta_pkg::AW-1:0]           square_value_o,
  output logic [4:0]                               cross_used_o,
  output logic [slta_pkg::IW-1:0]                  cross_col_o,
  output logic signed [slta_pkg::AW-1:0]           cross_value_o,
  output logic signed [slta_pkg::AW-1:0]           const_value_o
);
  import slta_pkg::*;

  localparam int FW     = $clog2(MAX_CROSS + 1);
  localparam int CW     = $clog2(MAX_LIST + 1);
  localparam int RDEPTH = VARS * MAX_CROSS;
  localparam int RW     = $clog2(RDEPTH);
  localparam int VW     = $clog2(VARS);

  function automatic logic [RW-1:0] row_addr(input logic [IW-1:0] r, input logic [RW-1:0] t);
    return RW'(r) * RW'(MAX_CROSS) + t;
  endfunction

  // Term memories.
  logic signed [AW-1:0] lin_mem [VARS];
  logic signed [AW-1:0] sq_mem  [VARS];
  logic [FW-1:0]        fill_mem [VARS];
  logic [IW-1:0]        col_mem [RDEPTH];
  logic signed [AW-1:0] val_mem [RDEPTH];

  logic                 lin_we, sq_we, var_re;
  logic [VW-1:0]        var_wa, var_ra;
  logic signed [AW-1:0] lin_wd, sq_wd, lin_rd_q, sq_rd_q;
  logic                 fill_we, fill_re;
  logic [VW-1:0]        fill_wa, fill_ra;
  logic [FW-1:0]        fill_wd, fill_rd_q;
  logic                 col_we, val_we, row_re;
  logic [RW-1:0]        row_wa, row_ra;
  logic [IW-1:0]        col_wd, col_rd_q;
  logic signed [AW-1:0] val_wd, val_rd_q;

  state_e               state_q, state_d;
  logic [RW-1:0]        cnt_q, cnt_d;
  logic signed [AW-1:0] const_q, const_d;

  logic                 res_valid_q, res_valid_d;
  status_e              res_sts_q, res_sts_d;
  logic signed [AW-1:0] res_lin_q, res_lin_d, res_sq_q, res_sq_d;
  logic [4:0]           res_used_q, res_used_d;
  logic [IW-1:0]        res_col_q, res_col_d;
  logic signed [AW-1:0] res_val_q, res_val_d, res_const_q, res_const_d;

  logic [IW-1:0]        pidx_q [MAX_LIST];
  logic [IW-1:0]        pidx_d [MAX_LIST];
  logic signed [WW-1:0] pwt_q  [MAX_LIST];
  logic signed [WW-1:0] pwt_d  [MAX_LIST];
  logic [IW-1:0]        qidx_q [MAX_LIST];
  logic [IW-1:0]        qidx_d [MAX_LIST];
  logic signed [WW-1:0] qwt_q  [MAX_LIST];
  logic signed [WW-1:0] qwt_d  [MAX_LIST];
  logic [CW-1:0]        pcnt_q, pcnt_d, qcnt_q, qcnt_d;
  logic signed [WW-1:0] cnst_q, cnst_d;
  logic                 drop_q, drop_d, rfull_q, rfull_d;
  logic [IW-1:0]        lo_q, lo_d, hi_q, hi_d;
  logic [FW-1:0]        n_q, n_d, t_q, t_d, t_nx;
  logic [3:0]           slot_q, slot_d;

  logic                 mul_en;
  logic signed [WW-1:0] mul_a, mul_b;
  logic signed [AW-1:0] prod_q;

  assign init_busy_o    = state_q == BK_INIT;
  assign empty_o        = !res_valid_q;
  assign status_o       = res_sts_q;
  assign linear_value_o = res_lin_q;
  assign square_value_o = res_sq_q;
  assign cross_used_o   = res_used_q;
  assign cross_col_o    = res_col_q;
  assign cross_value_o  = res_val_q;
  assign const_value_o  = res_const_q;
  assign t_nx           = t_q + FW'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    const_d     = const_q;
    res_valid_d = res_valid_q && !pop_i;
    res_sts_d   = res_sts_q;
    res_lin_d   = res_lin_q;
    res_sq_d    = res_sq_q;
    res_used_d  = res_used_q;
    res_col_d   = res_col_q;
    res_val_d   = res_val_q;
    res_const_d = res_const_q;
    pidx_d      = pidx_q;
    pwt_d       = pwt_q;
    qidx_d      = qidx_q;
    qwt_d       = qwt_q;
    pcnt_d      = pcnt_q;
    qcnt_d      = qcnt_q;
    cnst_d      = cnst_q;
    drop_d      = drop_q;
    rfull_d     = rfull_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    n_d         = n_q;
    t_d         = t_q;
    slot_d      = slot_q;
    q_pop_o     = 1'b0;
    mul_en      = 1'b0;
    mul_a       = pwt_q[0];
    mul_b       = cnst_q;
    lin_we      = 1'b0;
    sq_we       = 1'b0;
    var_re      = 1'b0;
    var_wa      = pidx_q[0];
    var_ra      = pidx_q[0];
    lin_wd      = '0;
    sq_wd       = '0;
    fill_we     = 1'b0;
    fill_re     = 1'b0;
    fill_wa     = lo_q;
    fill_ra     = lo_q;
    fill_wd     = '0;
    col_we      = 1'b0;
    val_we      = 1'b0;
    row_re      = 1'b0;
    row_wa      = row_addr(lo_q, RW'(t_q));
    row_ra      = row_addr(lo_q, RW'(t_q));
    col_wd      = hi_q;
    val_wd      = '0;

    case (state_q)
      BK_INIT: begin
        lin_we  = 1'b1;
        sq_we   = 1'b1;
        fill_we = 1'b1;
        var_wa  = cnt_q[VW-1:0];
        fill_wa = cnt_q[VW-1:0];
        if (cnt_q == RW'(VARS - 1)) begin
          cnt_d   = '0;
          state_d = BK_IDLE;
        end else begin
          cnt_d = cnt_q + RW'(1);
        end
      end

      BK_IDLE: begin
        if (q_valid_i && !res_valid_q) begin
          q_pop_o = 1'b1;
          case (cmd_i.kind)
            K_ACK: begin
              res_valid_d = 1'b1;
              res_sts_d   = cmd_i.sts;
              res_lin_d   = '0;
              res_sq_d    = '0;
              res_used_d  = '0;
              res_col_d   = '0;
              res_val_d   = '0;
              res_const_d = const_q;
            end
            K_READ: begin
              var_re  = 1'b1;
              var_ra  = cmd_i.idx;
              fill_re = 1'b1;
              fill_ra = cmd_i.idx;
              row_re  = 1'b1;
              row_ra  = (32'(cmd_i.slot) < MAX_CROSS) ?
                        row_addr(cmd_i.idx, RW'(cmd_i.slot)) : row_addr(cmd_i.idx, '0);
              slot_d  = cmd_i.slot;
              state_d = BK_RD_OUT;
            end
            K_CLEAR: begin
              const_d = '0;
              cnt_d   = '0;
              state_d = BK_CLR;
            end
            K_EQ: begin
              for (int i = 0; i < MAX_LIST; i++) begin
                pidx_d[i] = lidx_i[i*IW +: IW];
                pwt_d[i]  = lwt_i[i*WW +: WW];
              end
              pcnt_d  = cnt_i;
              cnst_d  = cmd_i.cnst;
              drop_d  = cmd_i.drop;
              rfull_d = 1'b0;
              state_d = BK_EQ_CSQ;
            end
            default: state_d = BK_IDLE;
          endcase
        end
      end

      BK_RD_OUT: begin
        res_valid_d = 1'b1;
        res_sts_d   = STS_DONE;
        res_lin_d   = lin_rd_q;
        res_sq_d    = sq_rd_q;
        res_used_d  = 5'(fill_rd_q);
        res_const_d = const_q;
        if (32'(slot_q) < 32'(fill_rd_q) && 32'(slot_q) < MAX_CROSS) begin
          res_col_d = col_rd_q;
          res_val_d = val_rd_q;
        end else begin
          res_col_d = '0;
          res_val_d = '0;
        end
        state_d = BK_IDLE;
      end

      BK_CLR: begin
        val_we = 1'b1;
        row_wa = cnt_q;
        var_wa = cnt_q[VW-1:0];
        if ({1'b0, cnt_q} < (RW+1)'(VARS)) begin
          lin_we = 1'b1;
          sq_we  = 1'b1;
        end
        if (cnt_q == RW'(RDEPTH - 1)) begin
          cnt_d       = '0;
          res_valid_d = 1'b1;
          res_sts_d   = STS_DONE;
          res_lin_d   = '0;
          res_sq_d    = '0;
          res_used_d  = '0;
          res_col_d   = '0;
          res_val_d   = '0;
          res_const_d = const_q;
          state_d     = BK_IDLE;
        end else begin
          cnt_d = cnt_q + RW'(1);
        end
      end

      BK_EQ_CSQ: begin
        mul_en  = 1'b1;
        mul_a   = cnst_q;
        mul_b   = cnst_q;
        state_d = BK_EQ_CADD;
      end

      BK_EQ_CADD: begin
        const_d = sat_add(const_q, prod_q);
        state_d = BK_P_NEXT;
      end

      BK_P_NEXT: begin
        if (pcnt_q == '0) begin
          res_valid_d = 1'b1;
          res_sts_d   = drop_q ? STS_BUF_FULL : (rfull_q ? STS_ROW_FULL : STS_DONE);
          res_lin_d   = '0;
          res_sq_d    = '0;
          res_used_d  = '0;
          res_col_d   = '0;
          res_val_d   = '0;
          res_const_d = const_q;
          state_d     = BK_IDLE;
        end else begin
          var_re  = 1'b1;
          mul_en  = 1'b1;
          state_d = BK_P_LIN;
        end
      end

      BK_P_LIN: begin
        lin_we  = 1'b1;
        lin_wd  = sat_add(lin_rd_q, sat_dbl(prod_q));
        mul_en  = 1'b1;
        mul_b   = pwt_q[0];
        state_d = BK_P_SQ;
      end

      BK_P_SQ: begin
        sq_we = 1'b1;
        sq_wd = sat_add(sq_rd_q, prod_q);
        for (int i = 0; i < MAX_LIST - 1; i++) begin
          qidx_d[i] = pidx_q[i+1];
          qwt_d[i]  = pwt_q[i+1];
        end
        qcnt_d  = pcnt_q - CW'(1);
        state_d = BK_Q_NEXT;
      end

      BK_Q_NEXT: begin
        if (qcnt_q == '0) begin
          for (int i = 0; i < MAX_LIST - 1; i++) begin
            pidx_d[i] = pidx_q[i+1];
            pwt_d[i]  = pwt_q[i+1];
          end
          pcnt_d  = pcnt_q - CW'(1);
          state_d = BK_P_NEXT;
        end else begin
          lo_d    = (pidx_q[0] < qidx_q[0]) ? pidx_q[0] : qidx_q[0];
          hi_d    = (pidx_q[0] < qidx_q[0]) ? qidx_q[0] : pidx_q[0];
          fill_re = 1'b1;
          fill_ra = lo_d;
          mul_en  = 1'b1;
          mul_b   = qwt_q[0];
          state_d = BK_Q_FILL;
        end
      end

      BK_Q_FILL: begin
        n_d = fill_rd_q;
        t_d = '0;
        if (fill_rd_q == '0) begin
          state_d = BK_Q_APP;
        end else begin
          row_re  = 1'b1;
          row_ra  = row_addr(lo_q, '0);
          state_d = BK_Q_CMP;
        end
      end

      BK_Q_CMP: begin
        if (col_rd_q == hi_q) begin
          val_we = 1'b1;
          val_wd = sat_add(val_rd_q, sat_dbl(prod_q));
          for (int i = 0; i < MAX_LIST - 1; i++) begin
            qidx_d[i] = qidx_q[i+1];
            qwt_d[i]  = qwt_q[i+1];
          end
          qcnt_d  = qcnt_q - CW'(1);
          state_d = BK_Q_NEXT;
        end else if (t_nx >= n_q) begin
          state_d = BK_Q_APP;
        end else begin
          t_d    = t_nx;
          row_re = 1'b1;
          row_ra = row_addr(lo_q, RW'(t_nx));
        end
      end

      BK_Q_APP: begin
        if (32'(n_q) >= MAX_CROSS) begin
          rfull_d = 1'b1;
        end else begin
          col_we  = 1'b1;
          val_we  = 1'b1;
          row_wa  = row_addr(lo_q, RW'(n_q));
          val_wd  = sat_dbl(prod_q);
          fill_we = 1'b1;
          fill_wd = n_q + FW'(1);
        end
        for (int i = 0; i < MAX_LIST - 1; i++) begin
          qidx_d[i] = qidx_q[i+1];
          qwt_d[i]  = qwt_q[i+1];
        end
        qcnt_d  = qcnt_q - CW'(1);
        state_d = BK_Q_NEXT;
      end

      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_INIT;
      cnt_q       <= '0;
      const_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      const_q     <= const_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_sts_q   <= res_sts_d;
    res_lin_q   <= res_lin_d;
    res_sq_q    <= res_sq_d;
    res_used_q  <= res_used_d;
    res_col_q   <= res_col_d;
    res_val_q   <= res_val_d;
    res_const_q <= res_const_d;
    pidx_q      <= pidx_d;
    pwt_q       <= pwt_d;
    qidx_q      <= qidx_d;
    qwt_q       <= qwt_d;
    pcnt_q      <= pcnt_d;
    qcnt_q      <= qcnt_d;
    cnst_q      <= cnst_d;
    drop_q      <= drop_d;
    rfull_q     <= rfull_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    n_q         <= n_d;
    t_q         <= t_d;
    slot_q      <= slot_d;
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lin_we) begin
      lin_mem[var_wa] <= lin_wd;
    end
    if (var_re) begin
      lin_rd_q <= lin_mem[var_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_we) begin
      sq_mem[var_wa] <= sq_wd;
    end
    if (var_re) begin
      sq_rd_q <= sq_mem[var_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    if (fill_re) begin
      fill_rd_q <= fill_mem[fill_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[row_wa] <= col_wd;
    end
    if (row_re) begin
      col_rd_q <= col_mem[row_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[row_wa] <= val_wd;
    end
    if (row_re) begin
      val_rd_q <= val_mem[row_ra];
    end
  end

endmodule
`default_nettype wire

>>> rtl/slta_checker.sv
`default_nettype none
module slta_checker #(
  parameter int MAX_CROSS = slta_pkg::DEF_MAX_CROSS
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  status_o,
  input wire logic [63:0] linear_value_o,
  input wire logic [63:0] square_value_o,
  input wire logic [4:0]  cross_used_o,
  input wire logic [9:0]  cross_col_o,
  input wire logic [63:0] cross_value_o,
  input wire logic [63:0] const_value_o
);
  import slta_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(status_o) && $stable(const_value_o))
    else $error("waiting result changed");

  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> 32'(cross_used_o) <= MAX_CROSS || MAX_CROSS > 31)
    else $error("row fill beyond capacity");

  a_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && cross_col_o != '0 |-> cross_used_o != '0)
    else $error("column from empty row");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o != STS_DONE |->
      linear_value_o == '0 && square_value_o == '0 && cross_used_o == '0 &&
      cross_col_o == '0 && cross_value_o == '0)
    else $error("element result carries row data");

endmodule

bind sparse_lsq_term_accumulator_unit slta_checker #(.MAX_CROSS(MAX_CROSS)) u_slta_checker (.*);
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import slta_pkg::*;

  localparam int NROWS = 1024;
  localparam int NSLOT = 16;
  localparam int NLIST = 8;
  localparam int RANDOM_ITEMS = 1800;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    req_e             req;
    logic [9:0]       idx;
    logic signed [31:0] w;
    logic signed [31:0] c;
    logic             last;
    logic [3:0]       slot;
  } term_req_t;

  typedef struct {
    logic [1:0]       sts;
    longint           lin;
    longint           sq;
    logic [4:0]       used;
    logic [9:0]       col;
    longint           cx;
    longint           cst;
  } term_rsp_t;

  // Scoreboard: mirrors the accumulator state and queues the expected responses.
  class term_scoreboard;
    longint    const_sum;
    longint    lin_sum[NROWS];
    longint    sq_sum[NROWS];
    int        fill[NROWS];
    logic [9:0] cols[NROWS][NSLOT];
    longint    vals[NROWS][NSLOT];
    logic [9:0] buf_idx[NLIST];
    longint    buf_wt[NLIST];
    int        buf_cnt;
    term_rsp_t pending_rsp[$];
    bit        failed;

    function void clear_all();
      const_sum = 0;
      buf_cnt = 0;
      failed = 0;
      for (int i = 0; i < NROWS; i++) begin
        lin_sum[i] = 0;
        sq_sum[i] = 0;
        fill[i] = 0;
      end
    endfunction

    function longint sat_sum(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? ACC_MIN : ACC_MAX;
      return s;
    endfunction

    function longint sat_twice(longint x);
      if (x[63] != x[62]) return x[63] ? ACC_MIN : ACC_MAX;
      return x <<< 1;
    endfunction

    // Find or append column hi in row lo; report false when the row has no room.
    function bit add_pair(int lo, logic [9:0] hi, longint v);
      int t;
      for (t = 0; t < fill[lo]; t++)
        if (cols[lo][t] == hi) break;
      if (t >= fill[lo]) begin
        if (fill[lo] >= NSLOT) return 0;
        t = fill[lo];
        cols[lo][t] = hi;
        vals[lo][t] = 0;
        fill[lo]++;
      end
      vals[lo][t] = sat_sum(vals[lo][t], v);
      return 1;
    endfunction

    function void note_input(term_req_t r);
      term_rsp_t e;
      bit dropped, row_full;
      longint cc, wp;
      int ip, iq;
      e = '{default: 0};
      e.sts = STS_DONE;
      case (r.req)
        REQ_ADD: begin
          dropped = 0;
          row_full = 0;
          if (buf_cnt < NLIST) begin
            buf_idx[buf_cnt] = r.idx;
            buf_wt[buf_cnt] = longint'(r.w);
            buf_cnt++;
          end else dropped = 1;
          if (!r.last) begin
            e.sts = dropped ? STS_BUF_FULL : STS_BUFFERED;
          end else begin
            cc = longint'(r.c);
            const_sum = sat_sum(const_sum, cc * cc);
            for (int p = 0; p < buf_cnt; p++) begin
              ip = buf_idx[p];
              wp = buf_wt[p];
              lin_sum[ip] = sat_sum(lin_sum[ip], sat_twice(wp * cc));
              sq_sum[ip] = sat_sum(sq_sum[ip], wp * wp);
              for (int q = p + 1; q < buf_cnt; q++) begin
                iq = buf_idx[q];
                if (!add_pair(ip < iq ? ip : iq, 10'(ip < iq ? iq : ip),
                              sat_twice(wp * buf_wt[q])))
                  row_full = 1;
              end
            end
            buf_cnt = 0;
            e.sts = dropped ? STS_BUF_FULL : (row_full ? STS_ROW_FULL : STS_DONE);
          end
        end
        REQ_CLEAR: begin
          // values go to zero, row structure and the element buffer stay
          const_sum = 0;
          for (int i = 0; i < NROWS; i++) begin
            lin_sum[i] = 0;
            sq_sum[i] = 0;
            for (int t = 0; t < fill[i]; t++) vals[i][t] = 0;
          end
        end
        REQ_READ: begin
          e.lin = lin_sum[r.idx];
          e.sq = sq_sum[r.idx];
          e.used = 5'(fill[r.idx]);
          if (r.slot < fill[r.idx]) begin
            e.col = cols[r.idx][r.slot];
            e.cx = vals[r.idx][r.slot];
          end
        end
        default: ;
      endcase
      e.cst = const_sum;
      pending_rsp.push_back(e);
    endfunction

    function void check_result(term_rsp_t a);
      term_rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("response with nothing outstanding");
        failed = 1;
        return;
      end
      e = pending_rsp.pop_front();
      if (a.sts !== e.sts) begin
        $error("status exp %0d got %0d", e.sts, a.sts); failed = 1;
      end
      if (a.lin !== e.lin) begin
        $error("linear_value exp %0d got %0d", e.lin, a.lin); failed = 1;
      end
      if (a.sq !== e.sq) begin
        $error("square_value exp %0d got %0d", e.sq, a.sq); failed = 1;
      end
      if (a.used !== e.used) begin
        $error("cross_used exp %0d got %0d", e.used, a.used); failed = 1;
      end
      if (a.col !== e.col) begin
        $error("cross_col exp %0d got %0d", e.col, a.col); failed = 1;
      end
      if (a.cx !== e.cx) begin
        $error("cross_value exp %0d got %0d", e.cx, a.cx); failed = 1;
      end
      if (a.cst !== e.cst) begin
        $error("const_value exp %0d got %0d", e.cst, a.cst); failed = 1;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [1:0]         req_type_i;
  logic [9:0]         var_index_i;
  logic signed [31:0] weight_i;
  logic signed [31:0] eq_constant_i;
  logic               last_element_i;
  logic [3:0]         slot_i;
  logic               empty;
  logic               pop;
  logic [1:0]         status_o;
  logic signed [63:0] linear_value_o;
  logic signed [63:0] square_value_o;
  logic [4:0]         cross_used_o;
  logic [9:0]         cross_col_o;
  logic signed [63:0] cross_value_o;
  logic signed [63:0] const_value_o;

  term_scoreboard sb;
  int             send_idle_pct;
  int             pop_stall_pct;
  longint         cycle_count;
  int             row_base;

  sparse_lsq_term_accumulator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type_i),
    .var_index_i   (var_index_i),
    .weight_i      (weight_i),
    .eq_constant_i (eq_constant_i),
    .last_element_i(last_element_i),
    .slot_i        (slot_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .linear_value_o(linear_value_o),
    .square_value_o(square_value_o),
    .cross_used_o  (cross_used_o),
    .cross_col_o   (cross_col_o),
    .cross_value_o (cross_value_o),
    .const_value_o (const_value_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Watchdog: a clear alone sweeps every row slot, so the limit is wide.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sparse_lsq_term_accumulator_unit regression: fail");
      $finish;
    end
  end

  // Result side: check on each transfer, then choose pop for the next edge.
  always @(posedge clk_i) begin
    term_rsp_t got;
    if (rst_ni && pop && !empty) begin
      got.sts = status_o;
      got.lin = linear_value_o;
      got.sq = square_value_o;
      got.used = cross_used_o;
      got.col = cross_col_o;
      got.cx = cross_value_o;
      got.cst = const_value_o;
      sb.check_result(got);
    end
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Drive one request and hold it until the transfer; lower push only across idle gaps.
  task automatic send_req(term_req_t r);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    req_type_i <= r.req;
    var_index_i <= r.idx;
    weight_i <= r.w;
    eq_constant_i <= r.c;
    last_element_i <= r.last;
    slot_i <= r.slot;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_input(r);
  endtask

  task automatic send_elem(logic [9:0] idx, logic signed [31:0] w, logic signed [31:0] c,
                           logic last);
    send_req('{REQ_ADD, idx, w, c, last, 4'($urandom)});
  endtask

  task automatic send_read(logic [9:0] idx, logic [3:0] slot);
    send_req('{REQ_READ, idx, $urandom, $urandom, 1'($urandom), slot});
  endtask

  function automatic logic signed [31:0] pick_weight();
    case ($urandom_range(9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3, 4: return $urandom;
      default: return $signed(32'($urandom_range(0, 1 << 21))) - (1 <<< 20);
    endcase
  endfunction

  // Pick mostly from a narrow window so rows collect partners and fill up.
  function automatic logic [9:0] pick_index();
    if ($urandom_range(9) < 8) return 10'(row_base + $urandom_range(0, 27));
    return 10'($urandom);
  endfunction

  task automatic send_equation(int n);
    for (int k = 0; k < n; k++)
      send_elem(pick_index(), pick_weight(), pick_weight(), k == n - 1);
  endtask

  initial begin
    int sent;
    int phase;
    sb = new();
    sb.clear_all();
    cycle_count = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    req_type_i = REQ_NONE;
    var_index_i = '0;
    weight_i = '0;
    eq_constant_i = '0;
    last_element_i = 1'b0;
    slot_i = '0;
    row_base = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, saturation, buffer overflow, slot past fill, unused type.
    send_elem(10'd0, 32'sh80000000, 32'sh80000000, 1'b0);
    send_elem(10'd1023, 32'sh80000000, 32'sh80000000, 1'b0);
    send_elem(10'd0, 32'sh7fffffff, 32'sh80000000, 1'b1);
    send_elem(10'd5, 32'sh7fffffff, 32'sh80000000, 1'b1);
    send_read(10'd0, 4'd0);
    send_read(10'd0, 4'd15);
    send_read(10'd1023, 4'd0);
    for (int k = 0; k < 10; k++)
      send_elem(10'(k + 1), 32'sh00010000, 32'sh7fffffff, k == 9);
    send_read(10'd1, 4'd6);
    send_req('{REQ_NONE, 10'd1023, 32'sh7fffffff, 32'sh80000000, 1'b1, 4'd15});
    send_req('{REQ_CLEAR, 10'd0, 0, 0, 1'b0, 4'd0});
    send_read(10'd1, 4'd0);
    send_read(10'd1023, 4'd1);

    // Random traffic through four idling phases.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase = sent * 4 / RANDOM_ITEMS;
      send_idle_pct = (phase == 1) ? 86 : (phase == 3) ? 10 : 0;
      pop_stall_pct = (phase == 2) ? 86 : (phase == 3) ? 10 : 0;
      if ($urandom_range(39) == 0) row_base = $urandom_range(0, 995);
      case ($urandom_range(99))
        0: begin
          if ($urandom_range(3) == 0) begin
            send_req('{REQ_CLEAR, 10'($urandom), $urandom, $urandom, 1'($urandom),
                       4'($urandom)});
            sent++;
          end
        end
        1, 2: begin
          send_req('{REQ_NONE, 10'($urandom), $urandom, $urandom, 1'($urandom),
                     4'($urandom)});
          sent++;
        end
        3, 4, 5, 6, 7: begin
          // noise: a lone or overflowing partial run left pending
          send_elem(pick_index(), pick_weight(), pick_weight(), 1'b0);
          sent++;
        end
        8, 9, 10, 11, 12: begin
          int n;
          n = $urandom_range(9, 11);
          send_equation(n);
          sent += n;
        end
        default: begin
          if ($urandom_range(2) == 0) begin
            send_read(($urandom_range(4) == 0) ? pick_index() : 10'(row_base),
                      4'($urandom));
            sent++;
          end else begin
            int n;
            n = $urandom_range(1, 8);
            send_equation(n);
            sent += n;
          end
        end
      endcase
    end
    // Flush whatever is still buffered so the last equation gets applied.
    send_elem(pick_index(), pick_weight(), pick_weight(), 1'b1);
    send_read(10'(row_base), 4'd0);
    push <= 1'b0;

    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (!sb.failed) begin
      $display("sparse_lsq_term_accumulator_unit regression: pass");
    end else begin
      $display("sparse_lsq_term_accumulator_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/slta_pkg.sv
rtl/slta_front.sv
rtl/slta_cmd_fifo.sv
rtl/slta_back.sv
rtl/sparse_lsq_term_accumulator_unit.sv
rtl/slta_checker.sv
test/tb_top.sv
